/* rtl/core/utf8_to_utf16_transcoder_macros.svh */
// Assertion macros shared by the UTF-8 to UTF-16 transcoder RTL.
`ifndef UTF8_TO_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define U8U16_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define U8U16_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/core/u8u16_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  localparam int POS_BITS = 32;

  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] LEAD_MIN  = 8'hC2;
  localparam logic [7:0] LEAD3     = 8'hE0;
  localparam logic [7:0] LEAD4     = 8'hF0;
  localparam logic [7:0] LEAD_END  = 8'hF5;

  localparam logic [20:0] MIN3    = 21'h000800;
  localparam logic [20:0] SUR_LO  = 21'h00D800;
  localparam logic [20:0] SUR_HI  = 21'h00DFFF;
  localparam logic [20:0] BOM_CP  = 21'h00FEFF;
  localparam logic [20:0] PLANE1  = 21'h010000;
  localparam logic [20:0] CP_MAX  = 21'h10FFFF;

  localparam logic [5:0] HI_SUR_TAG = 6'b110110;
  localparam logic [5:0] LO_SUR_TAG = 6'b110111;

  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  localparam int PADDR_W = 2;
  localparam logic [PADDR_W-1:0] REG_SKIP_BOM = 2'd0;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_LEAD = 3'd1,
    ERR_CONT = 3'd2,
    ERR_VAL3 = 3'd3,
    ERR_VAL4 = 3'd4
  } err_code_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_in;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] word_out;
    logic        word_valid;
    logic        run_last;
    logic        string_done;
    logic        err_flag;
    err_code_t   err_code;
    logic [31:0] err_offset;
  } out_beat_t;

  typedef struct packed {
    logic [1:0] count;
    out_beat_t  w0;
    out_beat_t  w1;
  } push_t;

endpackage

/* rtl/core/u8u16_decode.sv */
// Input register, sequence state and single-pass UTF-8 decode.
`include "utf8_to_utf16_transcoder_macros.svh"

module u8u16_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               skip_bom,
  input  logic               src_valid,
  output logic               src_stall,
  input  u8u16_pkg::in_beat_t src_data,
  input  logic               room,
  output u8u16_pkg::push_t   push
);
  import u8u16_pkg::*;

  logic                in_full;
  in_beat_t            in_beat;
  logic                proc;

  logic [20:0]         partial_cp, partial_cp_next;
  logic [1:0]          bytes_left, bytes_left_next;
  logic [2:0]          seq_len, seq_len_next;
  logic [POS_BITS-1:0] lead_offset, lead_offset_next;
  logic [POS_BITS-1:0] byte_count, byte_count_next;
  logic                discarding, discarding_next;
  logic                at_start, at_start_next;

  err_code_t           err;
  logic [POS_BITS-1:0] err_off;
  logic                have;
  logic [20:0]         cp;
  logic [20:0]         cp_rel;
  logic [1:0]          cnt;
  out_beat_t           w0, w1;

  assign proc      = in_full && room;
  assign src_stall = in_full && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!src_stall) begin
      in_full <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!src_stall && src_valid) begin
      in_beat <= src_data;
    end
  end

  // Sequence state and next-state decode
  always_comb begin
    partial_cp_next  = partial_cp;
    bytes_left_next  = bytes_left;
    seq_len_next     = seq_len;
    lead_offset_next = lead_offset;
    byte_count_next  = byte_count + POS_BITS'(1);
    discarding_next  = discarding;
    at_start_next    = at_start;
    err              = ERR_NONE;
    err_off          = '0;
    have             = 1'b0;
    cp               = '0;

    if (!discarding) begin
      if (bytes_left == 2'd0) begin
        if (in_beat.byte_in < CONT_TAG) begin
          cp   = {13'd0, in_beat.byte_in};
          have = 1'b1;
        end else if (in_beat.byte_in < LEAD_MIN || in_beat.byte_in >= LEAD_END) begin
          err     = ERR_LEAD;
          err_off = byte_count;
        end else begin
          lead_offset_next = byte_count;
          if (in_beat.byte_in < LEAD3) begin
            seq_len_next    = SEQ_LEN2;
            partial_cp_next = {16'd0, in_beat.byte_in[4:0]};
          end else if (in_beat.byte_in < LEAD4) begin
            seq_len_next    = SEQ_LEN3;
            partial_cp_next = {17'd0, in_beat.byte_in[3:0]};
          end else begin
            seq_len_next    = SEQ_LEN4;
            partial_cp_next = {18'd0, in_beat.byte_in[2:0]};
          end
          bytes_left_next = seq_len_next[1:0] - 2'd1;
          if (in_beat.end_in) begin
            err     = ERR_CONT;
            err_off = byte_count;
          end
        end
      end else if ((in_beat.byte_in & CONT_MASK) != CONT_TAG) begin
        err     = ERR_CONT;
        err_off = lead_offset;
      end else begin
        partial_cp_next = {partial_cp[14:0], in_beat.byte_in[5:0]};
        bytes_left_next = bytes_left - 2'd1;
        if (bytes_left_next == 2'd0) begin
          cp = partial_cp_next;
          if (seq_len == SEQ_LEN3 && (cp < MIN3 || (cp >= SUR_LO && cp <= SUR_HI))) begin
            err     = ERR_VAL3;
            err_off = lead_offset;
          end else if (seq_len == SEQ_LEN4 && (cp < PLANE1 || cp > CP_MAX)) begin
            err     = ERR_VAL4;
            err_off = lead_offset;
          end else begin
            have = 1'b1;
          end
        end else if (in_beat.end_in) begin
          err     = ERR_CONT;
          err_off = lead_offset;
        end
      end

      if (err != ERR_NONE) begin
        discarding_next = 1'b1;
        bytes_left_next = 2'd0;
        at_start_next   = 1'b0;
      end else if (have) begin
        at_start_next = 1'b0;
      end
    end

    if (in_beat.end_in) begin
      partial_cp_next  = '0;
      bytes_left_next  = 2'd0;
      seq_len_next     = 3'd0;
      lead_offset_next = '0;
      byte_count_next  = '0;
      discarding_next  = 1'b0;
      at_start_next    = 1'b1;
    end
  end

  // Result words for this beat
  always_comb begin
    w0     = '0;
    w1     = '0;
    cnt    = 2'd0;
    cp_rel = cp - PLANE1;

    if (err != ERR_NONE) begin
      w0.err_flag   = 1'b1;
      w0.err_code   = err;
      w0.err_offset = 32'(err_off);
      cnt           = 2'd1;
    end else if (have && !(at_start && skip_bom && cp == BOM_CP)) begin
      if (cp < PLANE1) begin
        w0.word_out   = cp[15:0];
        w0.word_valid = 1'b1;
        cnt           = 2'd1;
      end else begin
        w0.word_out   = {HI_SUR_TAG, cp_rel[19:10]};
        w0.word_valid = 1'b1;
        w1.word_out   = {LO_SUR_TAG, cp_rel[9:0]};
        w1.word_valid = 1'b1;
        cnt           = 2'd2;
      end
    end

    if (in_beat.end_in && cnt == 2'd0) begin
      cnt = 2'd1;
    end

    if (cnt == 2'd2) begin
      w1.run_last    = 1'b1;
      w1.string_done = in_beat.end_in;
    end else begin
      w0.run_last    = 1'b1;
      w0.string_done = in_beat.end_in;
    end

    push.count = proc ? cnt : 2'd0;
    push.w0    = w0;
    push.w1    = w1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_cp  <= '0;
      bytes_left  <= 2'd0;
      seq_len     <= 3'd0;
      lead_offset <= '0;
      byte_count  <= '0;
      discarding  <= 1'b0;
      at_start    <= 1'b1;
    end else if (proc) begin
      partial_cp  <= partial_cp_next;
      bytes_left  <= bytes_left_next;
      seq_len     <= seq_len_next;
      lead_offset <= lead_offset_next;
      byte_count  <= byte_count_next;
      discarding  <= discarding_next;
      at_start    <= at_start_next;
    end
  end

  `U8U16_IMPLY(a_err_alone, clk, rst, push.count != 2'd0 && push.w0.err_flag, push.count == 2'd1 && !push.w0.word_valid && push.w0.run_last)
  `U8U16_IMPLY(a_pair_tags, clk, rst, push.count == 2'd2, push.w0.word_out[15:10] == HI_SUR_TAG && push.w1.word_out[15:10] == LO_SUR_TAG && !push.w0.run_last)
  `U8U16_NEXT(a_discard, clk, rst, proc && push.w0.err_flag && !in_beat.end_in, discarding && bytes_left == 2'd0)

endmodule

/* rtl/core/u8u16_outq.sv */
// Four-entry result queue: takes up to two words a cycle while two entries are free, sends one unless dst stalls.
`include "utf8_to_utf16_transcoder_macros.svh"

module u8u16_outq (
  input  logic                clk,
  input  logic                rst,
  input  u8u16_pkg::push_t    push,
  output logic                room,
  output logic                dst_valid,
  input  logic                dst_stall,
  output u8u16_pkg::out_beat_t dst_data
);
  import u8u16_pkg::*;

  out_beat_t           slots [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OQ_CNT_W-1:0] count, count_next;
  logic                pop;

  assign room      = count <= OQ_CNT_W'(OQ_DEPTH - 2);
  assign dst_valid = count != '0;
  assign dst_data  = slots[rd_ptr];
  assign pop       = dst_valid && !dst_stall;

  assign count_next = count + OQ_CNT_W'(push.count) - OQ_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.w0;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr + OQ_PTR_W'(1)] <= push.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      end
      count <= count_next;
    end
  end

  `U8U16_IMPLY(a_push_room, clk, rst, push.count != 2'd0, room)
  `U8U16_NEXT(a_hold, clk, rst, dst_valid && dst_stall && push.count == 2'd0, $stable(count) && $stable(rd_ptr))
  `U8U16_IMPLY(a_count_max, clk, rst, 1'b1, count <= OQ_CNT_W'(OQ_DEPTH))

endmodule

/* rtl/core/utf8_to_utf16_transcoder.sv */
// Top level of the UTF-8 to UTF-16 transcoder with its register port.
//
// One UTF-8 byte per beat goes in on src; UTF-16 words, errors and end-of-string
// marks come out on dst, at most two results per byte. A byte can be taken every
// cycle while src does not stall: it is held in the input register, decoded there
// in one pass and written to a four-entry result queue, from which its first
// result shows on dst. A surrogate pair gives two dst words; the queue takes
// both words at once and src stalls only while fewer than two queue entries are
// free. Register skip_bom (address 0, reset 1) drops a leading U+FEFF; write it
// only while the block is idle. No clearing pass follows reset.
module utf8_to_utf16_transcoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 src_valid,
  output logic                                 src_stall,
  input  u8u16_pkg::in_beat_t                  src_data,
  output logic                                 dst_valid,
  input  logic                                 dst_stall,
  output u8u16_pkg::out_beat_t                 dst_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [u8u16_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import u8u16_pkg::*;

  logic  skip_bom;
  logic  room;
  push_t push;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_SKIP_BOM) ? {31'd0, skip_bom} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_bom <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr == REG_SKIP_BOM) begin
      skip_bom <= pwdata[0];
    end
  end

  u8u16_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .skip_bom  (skip_bom),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .room      (room),
    .push      (push)
  );

  u8u16_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

module tb_top;
  import u8u16_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_BYTES  = 500;
  localparam int SETTLE       = 8;

  typedef enum logic [1:0] {
    STALL_OFF,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        src_valid = 1'b0;
  logic        src_stall;
  in_beat_t    src_data = '0;
  logic        dst_valid;
  logic        dst_stall = 1'b0;
  out_beat_t   dst_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  utf8_to_utf16_transcoder DUT (
    .clk, .rst, .src_valid, .src_stall, .src_data, .dst_valid, .dst_stall,
    .dst_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Decoder state kept alongside the block
  logic [20:0] cp_acc = '0;
  logic [1:0]  remaining = '0;
  logic [2:0]  seq_bytes = '0;
  logic [31:0] lead_pos = '0;
  logic [31:0] pos_count = '0;
  logic        dropping = 1'b0;
  logic        fresh_string = 1'b1;
  logic        bom_skip = 1'b1;

  in_beat_t    pending_bytes[$];
  out_beat_t   expected_words[$];
  logic [7:0]  text_buf[$];

  int unsigned bytes_queued = 0;
  int unsigned bytes_driven = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned strings_seen = 0;
  int unsigned faults_seen = 0;
  int unsigned pairs_seen = 0;
  int unsigned boms_dropped = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  logic        src_taken = 1'b0;

  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  logic        drain_hold = 1'b0;
  stall_mode_t stall_mode = STALL_OFF;
  int unsigned stall_span = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_words.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic out_beat_t make_beat(logic [15:0] word, logic valid, err_code_t code,
                                          logic [31:0] off);
    out_beat_t r;
    r = '0;
    r.word_out   = word;
    r.word_valid = valid;
    r.err_flag   = (code != ERR_NONE);
    r.err_code   = code;
    r.err_offset = off;
    return r;
  endfunction

  // Expected results for one accepted byte
  task automatic decode_byte(input in_beat_t beat);
    logic [7:0]  b;
    logic        last;
    logic [31:0] pos;
    err_code_t   fault;
    logic [31:0] fault_pos;
    logic        have;
    logic [20:0] cp;
    logic [19:0] v;
    out_beat_t   res[2];
    int          n;
    b = beat.byte_in;
    last = beat.end_in;
    pos = pos_count;
    fault = ERR_NONE;
    fault_pos = '0;
    have = 1'b0;
    cp = '0;
    n = 0;
    pos_count = pos_count + 32'd1;
    if (!dropping) begin
      if (remaining == 2'd0) begin
        if (b < CONT_TAG) begin
          cp = {13'd0, b};
          have = 1'b1;
        end else if (b < LEAD_MIN || b >= LEAD_END) begin
          fault = ERR_LEAD;
          fault_pos = pos;
        end else begin
          lead_pos = pos;
          if (b < LEAD3) begin
            seq_bytes = SEQ_LEN2;
            cp_acc = {16'd0, b[4:0]};
          end else if (b < LEAD4) begin
            seq_bytes = SEQ_LEN3;
            cp_acc = {17'd0, b[3:0]};
          end else begin
            seq_bytes = SEQ_LEN4;
            cp_acc = {18'd0, b[2:0]};
          end
          remaining = 2'(seq_bytes - 3'd1);
          if (last) begin
            fault = ERR_CONT;
            fault_pos = lead_pos;
          end
        end
      end else if ((b & CONT_MASK) != CONT_TAG) begin
        fault = ERR_CONT;
        fault_pos = lead_pos;
      end else begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        remaining = remaining - 2'd1;
        if (remaining == 2'd0) begin
          cp = cp_acc;
          if (seq_bytes == SEQ_LEN3 && (cp < MIN3 || (cp >= SUR_LO && cp <= SUR_HI))) begin
            fault = ERR_VAL3;
            fault_pos = lead_pos;
          end else if (seq_bytes == SEQ_LEN4 && (cp < PLANE1 || cp > CP_MAX)) begin
            fault = ERR_VAL4;
            fault_pos = lead_pos;
          end else begin
            have = 1'b1;
          end
        end else if (last) begin
          fault = ERR_CONT;
          fault_pos = lead_pos;
        end
      end

      if (fault != ERR_NONE) begin
        res[n] = make_beat('0, 1'b0, fault, fault_pos);
        n = n + 1;
        faults_seen++;
        dropping = 1'b1;
        remaining = '0;
        fresh_string = 1'b0;
      end else if (have) begin
        if (fresh_string && bom_skip && cp == BOM_CP) begin
          boms_dropped++;
        end else if (cp < PLANE1) begin
          res[n] = make_beat(cp[15:0], 1'b1, ERR_NONE, '0);
          n = n + 1;
        end else begin
          v = 20'(cp - PLANE1);
          res[n] = make_beat({HI_SUR_TAG, v[19:10]}, 1'b1, ERR_NONE, '0);
          n = n + 1;
          res[n] = make_beat({LO_SUR_TAG, v[9:0]}, 1'b1, ERR_NONE, '0);
          n = n + 1;
          pairs_seen++;
        end
        fresh_string = 1'b0;
      end
    end

    if (last && n == 0) begin
      res[n] = make_beat('0, 1'b0, ERR_NONE, '0);
      n = n + 1;
    end
    if (n > 0) begin
      res[n-1].run_last = 1'b1;
      res[n-1].string_done = last;
    end
    for (int i = 0; i < n; i++) expected_words.push_back(res[i]);
    if (last) begin
      strings_seen++;
      cp_acc = '0;
      remaining = '0;
      seq_bytes = '0;
      lead_pos = '0;
      pos_count = '0;
      dropping = 1'b0;
      fresh_string = 1'b1;
    end
  endtask

  // Monitor: predicts on each accepted byte, checks each accepted result
  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      src_taken = 1'b0;
    end else begin
      src_taken = src_valid && !src_stall;
      if (src_taken) begin
        decode_byte(src_data);
        bytes_sent++;
      end
      if (dst_valid && !dst_stall) begin
        results_seen++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cycle %0d: unexpected result word %h valid %b code %0d off %0d",
                     cycles, dst_data.word_out, dst_data.word_valid, dst_data.err_code,
                     dst_data.err_offset);
        end else begin
          want = expected_words.pop_front();
          if (dst_data.word_out !== want.word_out || dst_data.word_valid !== want.word_valid ||
              dst_data.run_last !== want.run_last ||
              dst_data.string_done !== want.string_done ||
              dst_data.err_flag !== want.err_flag || dst_data.err_code !== want.err_code ||
              dst_data.err_offset !== want.err_offset) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("cycle %0d: mismatch on result %0d", cycles, results_seen);
              $display("  expected word %h valid %b last %b done %b err %b code %0d off %0d",
                       want.word_out, want.word_valid, want.run_last, want.string_done,
                       want.err_flag, want.err_code, want.err_offset);
              $display("  actual   word %h valid %b last %b done %b err %b code %0d off %0d",
                       dst_data.word_out, dst_data.word_valid, dst_data.run_last,
                       dst_data.string_done, dst_data.err_flag, dst_data.err_code,
                       dst_data.err_offset);
            end
          end
        end
      end
    end
  end

  // Byte driver: bursts with random gaps, an occasional full drain
  always @(negedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else if (!src_valid || src_taken) begin
      if (drain_hold) begin
        src_valid <= 1'b0;
        if (expected_words.size() == 0 && bytes_driven == bytes_sent) drain_hold = 1'b0;
      end else if (gap_left != 0) begin
        src_valid <= 1'b0;
        gap_left--;
      end else if (pending_bytes.size() != 0) begin
        src_data <= pending_bytes.pop_front();
        src_valid <= 1'b1;
        bytes_driven++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if ($urandom_range(0, 49) == 0) drain_hold = 1'b1;
        end
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      dst_stall <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_span = $urandom_range(50, 300);
      end
      stall_span--;
      case (stall_mode)
        STALL_OFF:      dst_stall <= 1'b0;
        STALL_LIGHT:    dst_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    dst_stall <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: dst_stall <= ((cycles % 5) < 2);
        default:        dst_stall <= 1'b0;
      endcase
    end
  end

  task automatic flush_string();
    for (int i = 0; i < text_buf.size(); i++) begin
      pending_bytes.push_back('{byte_in: text_buf[i], end_in: (i == text_buf.size() - 1)});
      bytes_queued++;
    end
    text_buf.delete();
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  task automatic encode_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      text_buf.push_back(cp[7:0]);
    end else if (cp < MIN3) begin
      text_buf.push_back({3'b110, cp[10:6]});
      text_buf.push_back({2'b10, cp[5:0]});
    end else if (cp < PLANE1) begin
      text_buf.push_back({4'b1110, cp[15:12]});
      text_buf.push_back({2'b10, cp[11:6]});
      text_buf.push_back({2'b10, cp[5:0]});
    end else begin
      text_buf.push_back({5'b11110, cp[20:18]});
      text_buf.push_back({2'b10, cp[17:12]});
      text_buf.push_back({2'b10, cp[11:6]});
      text_buf.push_back({2'b10, cp[5:0]});
    end
  endtask

  task automatic add_malformed();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: text_buf.push_back(8'($urandom));
      1: text_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hC1))
                                                 : 8'($urandom_range(8'hF5, 8'hFF)));
      2: begin
        b = 8'($urandom_range(LEAD_MIN, 8'hF4));
        text_buf.push_back(b);
        if (b >= LEAD3 && $urandom_range(0, 1) == 1) text_buf.push_back(cont_byte());
        b = 8'($urandom);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        text_buf.push_back(b);
      end
      3: text_buf = {text_buf, 8'hE0, 8'($urandom_range(8'h80, 8'h9F)), cont_byte()};
      4: text_buf = {text_buf, 8'hED, 8'($urandom_range(8'hA0, 8'hBF)), cont_byte()};
      5: text_buf = {text_buf, 8'hF0, 8'($urandom_range(8'h80, 8'h8F)), cont_byte(),
                     cont_byte()};
      6: text_buf = {text_buf, 8'hF4, 8'($urandom_range(8'h90, 8'hBF)), cont_byte(),
                     cont_byte()};
      default: text_buf = {text_buf, 8'($urandom_range(8'hC0, 8'hC1)), cont_byte()};
    endcase
  endtask

  task automatic add_random_string();
    int          n;
    int          k;
    int          len;
    logic [20:0] cp;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) encode_cp(BOM_CP);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 30) begin
        encode_cp(21'($urandom_range(0, 8'h7F)));
      end else if (k < 50) begin
        encode_cp(21'($urandom_range(21'h80, 21'h7FF)));
      end else if (k < 70) begin
        cp = 21'($urandom_range(MIN3, 21'hFFFF));
        if (cp >= SUR_LO && cp <= SUR_HI) cp = cp ^ 21'h4000;
        encode_cp(cp);
      end else if (k < 85) begin
        encode_cp(21'($urandom_range(PLANE1, CP_MAX)));
      end else if (k < 95) begin
        add_malformed();
      end else begin
        encode_cp(BOM_CP);
      end
    end
    // string cut off inside a sequence
    if ($urandom_range(0, 7) == 0) begin
      len = $urandom_range(2, 4);
      case (len)
        2:       text_buf.push_back(8'($urandom_range(LEAD_MIN, 8'hDF)));
        3:       text_buf.push_back(8'($urandom_range(LEAD3, 8'hEF)));
        default: text_buf.push_back(8'($urandom_range(LEAD4, 8'hF4)));
      endcase
      repeat ($urandom_range(0, len - 2)) text_buf.push_back(cont_byte());
    end
    if (text_buf.size() == 0) text_buf.push_back(8'($urandom_range(0, 8'h7F)));
    flush_string();
  endtask

  task automatic fill_random(input int unsigned count);
    int unsigned target;
    @(posedge clk);
    target = bytes_queued + count;
    while (bytes_queued < target) add_random_string();
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (!(bytes_sent == bytes_queued && expected_words.size() == 0));
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_skip_bom(input logic value);
    logic [31:0] rd;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_SKIP_BOM;
    pwdata <= {31'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== {31'd0, value}) begin
      mismatches++;
      if (mismatches <= 10) $display("skip_bom readback %h, wrote %b", rd, value);
    end
    bom_skip = value;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed strings, skip_bom at its reset value
    @(posedge clk);
    text_buf = '{8'hEF, 8'hBB, 8'hBF, 8'h00, 8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    flush_string();
    text_buf = '{8'hFF};
    flush_string();
    text_buf = '{8'hC3, 8'h41, 8'h80};
    flush_string();
    text_buf = '{8'hE2, 8'h82};
    flush_string();
    text_buf = '{8'hED, 8'hA0, 8'h80};
    flush_string();
    text_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};
    flush_string();
    wait_idle();

    set_skip_bom(1'b0);
    fill_random(PHASE_BYTES);
    wait_idle();
    set_skip_bom(1'b1);
    fill_random(PHASE_BYTES);
    wait_idle();
    set_skip_bom(1'b0);
    fill_random(PHASE_BYTES);
    wait_idle();

    $display("summary: %0d bytes in %0d strings, %0d results checked", bytes_sent,
             strings_seen, results_seen);
    $display("summary: %0d errors, %0d surrogate pairs, %0d byte order marks dropped",
             faults_seen, pairs_seen, boms_dropped);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* utf8_to_utf16_transcoder.f */
+incdir+rtl/core
rtl/core/u8u16_pkg.sv
rtl/core/u8u16_decode.sv
rtl/core/u8u16_outq.sv
rtl/core/utf8_to_utf16_transcoder.sv
tb/tb_top.sv
